### sv/assert_macros.svh
// Assertion macros shared by the scorer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same, but the consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/wkms_pkg.sv
// Constants, keyword tables and shared types of the keyword match scorer.
package wkms_pkg;

   localparam int KEY_COUNT   = 30;
   localparam int MAX_KEY_LEN = 27;
   localparam int COUNT_BITS  = 16;

   localparam int BYTE_BITS   = 8;
   localparam int WIN_DEPTH   = MAX_KEY_LEN - 1;
   localparam int WIN_BITS    = MAX_KEY_LEN * BYTE_BITS;
   localparam int FILL_BITS   = $clog2(MAX_KEY_LEN);
   localparam int IDX_BITS    = 5;
   localparam int POINT_BITS  = 22;
   localparam int WEIGHT_BITS = 2;
   localparam int PROD_BITS   = COUNT_BITS + WEIGHT_BITS;

   typedef logic [KEY_COUNT-1:0]                 hit_vec_type;
   typedef logic [COUNT_BITS-1:0]                count_type;
   typedef logic [KEY_COUNT-1:0][COUNT_BITS-1:0] count_vec_type;

   localparam count_type COUNT_MAX = '1;

   // Keyword text, right-aligned: the last character sits in the low byte.
   localparam logic [WIN_BITS-1:0] KEY_TEXT [KEY_COUNT] = '{
      "urgent",
      "credit card",
      "account",
      "personal information",
      "SSN",
      "verify",
      "placed on hold",
      "bank",
      "update",
      "security",
      "fraud",
      "password",
      "alert",
      "invoice",
      "important",
      "login",
      "as soon as possible",
      216'h4F75746C6F6F6B,
      216'h4170706C65,
      216'h50617950616C,
      216'h416D617A6F6E,
      216'h4E6574666C6978,
      216'h476F6F676C65,
      "locked for security reasons",
      "click the link",
      "free",
      "hurry",
      "suspicious",
      "action required",
      "Expiration notice"
   };

   localparam logic [FILL_BITS-1:0] KEY_LEN [KEY_COUNT] = '{
      5'd6,  5'd11, 5'd7,  5'd20, 5'd3,  5'd6,  5'd14, 5'd4,  5'd6,  5'd8,
      5'd5,  5'd8,  5'd5,  5'd7,  5'd9,  5'd5,  5'd19, 5'd7,  5'd5,  5'd6,
      5'd6,  5'd7,  5'd6,  5'd27, 5'd14, 5'd4,  5'd5,  5'd10, 5'd15, 5'd17
   };

   localparam logic [WEIGHT_BITS-1:0] KEY_WEIGHT [KEY_COUNT] = '{
      2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2,
      2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd2,
      2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2
   };

endpackage

### sv/weighted_keyword_match_scorer_core.sv
// Top level of the weighted keyword match scorer.
//
// Request channel (req_*): one message byte per word, with req_end_of_message
// set on the last byte. Every byte is compared against all 30 keywords in
// parallel; a byte is taken every cycle while req_stall is low.
// Result channel (rsp_*): after the last byte, 31 words: one per
// keyword (index, saturated count, count times weight), then a total word
// with rsp_last_of_report set and the summed points.
// The report then runs one word per cycle while the receiver does not stall.
// At message end the counts move to a report snapshot and the live counters
// and window clear, so the next message streams in while the report drains.
// An end-of-message byte that arrives before the previous report finishes
// waits in the input register (req_stall high) until the report is done.
// Reports therefore start only once the previous 31 words are sent and the
// engine has gone idle; only then is the next snapshot taken.
// A stalled receiver holds the output register; the report engine waits and
// ordinary bytes keep flowing. Synchronous reset clears the window, the
// counters, the report engine and both valid flags.
module weighted_keyword_match_scorer_core
   import wkms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_BITS-1:0]  req_text_byte,
   input  logic                  req_end_of_message,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_BITS-1:0]   rsp_entry_index,
   output logic [COUNT_BITS-1:0] rsp_occurrences,
   output logic [POINT_BITS-1:0] rsp_points,
   output logic                  rsp_last_of_report
);

   logic          rpt_start;
   logic          rpt_busy;
   count_vec_type snap_counts;

   wkms_scan u_scan (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_end_of_message (req_end_of_message),
      .rpt_busy           (rpt_busy),
      .rpt_start          (rpt_start),
      .snap_counts        (snap_counts)
   );

   wkms_report u_report (
      .clock              (clock),
      .reset              (reset),
      .rpt_start          (rpt_start),
      .snap_counts        (snap_counts),
      .rpt_busy           (rpt_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_points         (rsp_points),
      .rsp_last_of_report (rsp_last_of_report)
   );

endmodule

### sv/wkms_matcher.sv
// Parallel keyword comparators against the byte window.
module wkms_matcher
   import wkms_pkg::*;
(
   input  logic [WIN_BITS-1:0]  window,
   input  logic [FILL_BITS-1:0] fill,
   output hit_vec_type          hits
);

   // window byte 0 is the current byte, byte j the j-th byte before it
   function automatic logic key_hit(input logic [WIN_BITS-1:0] win,
                                    input logic [FILL_BITS-1:0] fl,
                                    input int k);
      logic ok;
      ok = (fl >= KEY_LEN[k] - FILL_BITS'(1));
      for (int j = 0; j < MAX_KEY_LEN; j++) begin
         if ((FILL_BITS'(j) < KEY_LEN[k]) &&
             (win[j*BYTE_BITS +: BYTE_BITS] != KEY_TEXT[k][j*BYTE_BITS +: BYTE_BITS])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
      assign hits[k] = key_hit(window, fill, k);
   end

endmodule

### sv/wkms_scan.sv
// Input register, byte window and live match counters.
module wkms_scan
   import wkms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_BITS-1:0] req_text_byte,
   input  logic                 req_end_of_message,
   input  logic                 rpt_busy,
   output logic                 rpt_start,
   output count_vec_type        snap_counts
);

`include "assert_macros.svh"

   logic                            in_valid_ff;
   logic [BYTE_BITS-1:0]            in_byte_ff;
   logic                            in_eom_ff;
   logic [WIN_DEPTH*BYTE_BITS-1:0]  recent_ff;
   logic [WIN_DEPTH*BYTE_BITS-1:0]  recent_in;
   logic [FILL_BITS-1:0]            fill_ff;
   logic [FILL_BITS-1:0]            fill_in;
   count_vec_type                   counts_ff;
   count_vec_type                   counts_in;
   hit_vec_type                     hits;
   logic                            process;

   // an end-of-message word waits here while the previous report drains
   assign process   = in_valid_ff && !(in_eom_ff && rpt_busy);
   assign req_stall = in_valid_ff && !process;
   assign rpt_start = process && in_eom_ff;

   wkms_matcher u_matcher (
      .window (({recent_ff, in_byte_ff})),
      .fill   (fill_ff),
      .hits   (hits)
   );

   always_comb begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         counts_in[k] = counts_ff[k] +
                        COUNT_BITS'(hits[k] && (counts_ff[k] != COUNT_MAX));
      end
      recent_in = {recent_ff[(WIN_DEPTH-1)*BYTE_BITS-1:0], in_byte_ff};
      fill_in   = (fill_ff == FILL_BITS'(WIN_DEPTH)) ? fill_ff : fill_ff + FILL_BITS'(1);
   end

   assign snap_counts = counts_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_text_byte;
         in_eom_ff  <= req_end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         fill_ff   <= '0;
         counts_ff <= '0;
      end else if (process) begin
         if (in_eom_ff) begin
            recent_ff <= '0;
            fill_ff   <= '0;
            counts_ff <= '0;
         end else begin
            recent_ff <= recent_in;
            fill_ff   <= fill_in;
            counts_ff <= counts_in;
         end
      end
   end

   `ASSERT_CLK(a_stall_cause, !req_stall || (in_valid_ff && in_eom_ff && rpt_busy), "stall without a pending end-of-message word")
   `ASSERT_NEXT(a_clear_after_eom, rpt_start, (fill_ff == '0) && (counts_ff == '0), "state not cleared after message end")
   `ASSERT_CLK(a_fill_bound, fill_ff <= FILL_BITS'(WIN_DEPTH), "window fill past depth")

endmodule

### sv/wkms_report.sv
// Report snapshot, points computation and result register.
module wkms_report
   import wkms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rpt_start,
   input  count_vec_type         snap_counts,
   output logic                  rpt_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [IDX_BITS-1:0]   rsp_entry_index,
   output logic [COUNT_BITS-1:0] rsp_occurrences,
   output logic [POINT_BITS-1:0] rsp_points,
   output logic                  rsp_last_of_report
);

`include "assert_macros.svh"

   localparam logic [IDX_BITS-1:0] TOTAL_IDX = IDX_BITS'(KEY_COUNT);

   logic                   busy_ff;
   logic [IDX_BITS-1:0]    idx_ff;
   logic [POINT_BITS-1:0]  total_ff;
   count_vec_type          snap_ff;
   logic                   emit;
   logic                   is_total;
   logic [WEIGHT_BITS-1:0] weight;
   logic [PROD_BITS-1:0]   prod;
   logic [POINT_BITS-1:0]  pts;

   logic                   rsp_valid_ff;
   logic [IDX_BITS-1:0]    rsp_idx_ff;
   logic [COUNT_BITS-1:0]  rsp_occ_ff;
   logic [POINT_BITS-1:0]  rsp_pts_ff;
   logic                   rsp_last_ff;

   assign emit     = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign is_total = (idx_ff == TOTAL_IDX);

   always_comb begin
      weight = '0;
      if (!is_total) begin
         weight = KEY_WEIGHT[idx_ff];
      end
      prod = PROD_BITS'(snap_ff[0]) * PROD_BITS'(weight);
      pts  = POINT_BITS'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (rpt_start) begin
         busy_ff <= 1'b1;
      end else if (emit && is_total) begin
         busy_ff <= 1'b0;
      end
   end

   // snapshot shifts down one keyword per keyword word sent; head is always slot 0
   always_ff @(posedge clock) begin
      if (rpt_start) begin
         snap_ff  <= snap_counts;
         idx_ff   <= '0;
         total_ff <= '0;
      end else if (emit && !is_total) begin
         snap_ff  <= {count_type'(0), snap_ff[KEY_COUNT-1:1]};
         idx_ff   <= idx_ff + IDX_BITS'(1);
         total_ff <= total_ff + pts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_idx_ff  <= idx_ff;
         rsp_occ_ff  <= is_total ? '0 : snap_ff[0];
         rsp_pts_ff  <= is_total ? total_ff : pts;
         rsp_last_ff <= is_total;
      end
   end

   assign rpt_busy           = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_index    = rsp_idx_ff;
   assign rsp_occurrences    = rsp_occ_ff;
   assign rsp_points         = rsp_pts_ff;
   assign rsp_last_of_report = rsp_last_ff;

   `ASSERT_CLK(a_start_idle, !rpt_start || !busy_ff, "report started while one is in progress")
   `ASSERT_NEXT(a_start_init, rpt_start, busy_ff && (idx_ff == '0) && (total_ff == '0), "report not initialized")
   `ASSERT_NEXT(a_total_ends, emit && is_total, !busy_ff, "report still busy after total word")
   `ASSERT_CLK(a_idx_bound, !busy_ff || (idx_ff <= TOTAL_IDX), "report index out of range")

endmodule
